@@ sv/tpd_pkg.sv @@
// Shared types and constants for the tone pulse detector.
`timescale 1ns / 1ps

package tpd_pkg;

    localparam int ADDR_W     = 5;
    localparam int IN_W       = 24;
    localparam int LEVEL_W    = 28;
    localparam int THR_W      = 32;
    localparam int CNT_W      = 16;
    localparam int LEN_W      = 6;
    localparam int TDATA_W    = 192;
    localparam int TUSER_W    = 3;
    localparam int PROD_W     = 44;

    localparam logic [31:0]      WARM_LAST  = 32'd50;
    localparam logic [15:0]      WARM_RATE  = 16'd1311;
    localparam logic [27:0]      BASE_FLOOR = 28'd7;
    localparam logic [27:0]      MAX28      = 28'hFFF_FFFF;
    localparam logic [31:0]      THR_RESET  = 32'd14;
    localparam logic [1:0]       LOW_NEEDED = 2'd3;
    localparam logic [LEN_W-1:0] LEN_MAX    = 6'd63;
    localparam logic [CNT_W-1:0] CNT_MAX    = 16'hFFFF;

    localparam logic        ENABLE_RST   = 1'b1;
    localparam logic [15:0] GAIN_RST     = 16'd512;
    localparam logic [15:0] RATE_RST     = 16'd66;
    localparam logic [5:0]  MIN_RST      = 6'd3;
    localparam logic [5:0]  MAX_RST      = 6'd25;
    localparam logic [5:0]  TIMEOUT_RST  = 6'd49;
    localparam logic [5:0]  COOL_RST     = 6'd12;
    localparam logic [9:0]  STARTUP_RST  = 10'd123;

    typedef enum logic [2:0] {
        REG_ENABLE   = 3'd0,
        REG_GAIN     = 3'd1,
        REG_RATE     = 3'd2,
        REG_MIN      = 3'd3,
        REG_MAX      = 3'd4,
        REG_TIMEOUT  = 3'd5,
        REG_COOLDOWN = 3'd6,
        REG_STARTUP  = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_PULSE = 2'd1,
        MODE_COOL  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PH_WARM = 2'd0,
        PH_HOLD = 2'd1,
        PH_RUN  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_VALID   = 2'd1,
        KIND_LENGTH  = 2'd2,
        KIND_TIMEOUT = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_WAIT   = 4'd0,
        ST_SUM    = 4'd1,
        ST_AMUL   = 4'd2,
        ST_AADD   = 4'd3,
        ST_TMUL   = 4'd4,
        ST_DECIDE = 4'd5,
        ST_RMUL   = 4'd6,
        ST_RLOAD  = 4'd7,
        ST_OUT    = 4'd8
    } state_t;

    typedef struct packed {
        logic        enable;
        logic [15:0] gain;
        logic [15:0] rate;
        logic [5:0]  min_len;
        logic [5:0]  max_len;
        logic [5:0]  timeout;
        logic [5:0]  cooldown;
        logic [9:0]  startup;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic sum;
        logic amul;
        logic aadd;
        logic tmul;
        logic decide;
        logic rload;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic enable;
        logic reload;
        logic out_free;
    } stat_t;

endpackage

@@ sv/tone_pulse_detector_adaptive_baseline_unit.sv @@
// Top level: register port, sequencer and datapath of the tone pulse detector.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one tone-bin magnitude per frame, Q8.16.
//   m_tvalid/m_tready/m_tdata/m_tuser carry one result beat per input beat:
//   event fields, current window sum, baseline, threshold and pulse counts.
//   The APB port sets enable, gain, rate and pulse limits; change them only
//   while no frame is in flight.
// Sequence:
//   An enabled frame steps through ring read, window sum, baseline multiply,
//   baseline add, threshold multiply and decision, each in a sequencer state
//   of its own, then loads the result register. When a timed-out pulse reloads
//   the baseline, the threshold is computed again before the result is loaded.
//   A disabled frame skips the chain and loads the result register directly.
//   s_tready is high only between frames, so one frame is in work at a time.
// Reset:
//   rst_n clears the window, the pulse tracker, counters and registers to
//   their defaults; the baseline starts at its floor.
// Stall:
//   A held result waits in the output register; the next frame is accepted
//   and worked, then waits until the held beat is taken.
`timescale 1ns / 1ps

module tone_pulse_detector_adaptive_baseline_unit #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpd_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // bin_energy
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // event_start, event_length, event_peak, level_sum, level_base,
    // level_thresh, good_count, bad_count, zero pad
    output logic [tpd_pkg::TDATA_W-1:0]   m_tdata,
    // pulse_started, event_kind
    output logic [tpd_pkg::TUSER_W-1:0]   m_tuser
);

    tpd_pkg::cfg_t     cfg_reg;
    tpd_pkg::cmd_t     cmd;
    tpd_pkg::stat_t    stat;
    tpd_pkg::reg_idx_t reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = tpd_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable   <= tpd_pkg::ENABLE_RST;
            cfg_reg.gain     <= tpd_pkg::GAIN_RST;
            cfg_reg.rate     <= tpd_pkg::RATE_RST;
            cfg_reg.min_len  <= tpd_pkg::MIN_RST;
            cfg_reg.max_len  <= tpd_pkg::MAX_RST;
            cfg_reg.timeout  <= tpd_pkg::TIMEOUT_RST;
            cfg_reg.cooldown <= tpd_pkg::COOL_RST;
            cfg_reg.startup  <= tpd_pkg::STARTUP_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                tpd_pkg::REG_ENABLE:   cfg_reg.enable   <= pwdata[0];
                tpd_pkg::REG_GAIN:     cfg_reg.gain     <= pwdata[15:0];
                tpd_pkg::REG_RATE:     cfg_reg.rate     <= pwdata[15:0];
                tpd_pkg::REG_MIN:      cfg_reg.min_len  <= pwdata[5:0];
                tpd_pkg::REG_MAX:      cfg_reg.max_len  <= pwdata[5:0];
                tpd_pkg::REG_TIMEOUT:  cfg_reg.timeout  <= pwdata[5:0];
                tpd_pkg::REG_COOLDOWN: cfg_reg.cooldown <= pwdata[5:0];
                tpd_pkg::REG_STARTUP:  cfg_reg.startup  <= pwdata[9:0];
                default:               cfg_reg.enable   <= cfg_reg.enable;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            tpd_pkg::REG_ENABLE:   prdata = {31'd0, cfg_reg.enable};
            tpd_pkg::REG_GAIN:     prdata = {16'd0, cfg_reg.gain};
            tpd_pkg::REG_RATE:     prdata = {16'd0, cfg_reg.rate};
            tpd_pkg::REG_MIN:      prdata = {26'd0, cfg_reg.min_len};
            tpd_pkg::REG_MAX:      prdata = {26'd0, cfg_reg.max_len};
            tpd_pkg::REG_TIMEOUT:  prdata = {26'd0, cfg_reg.timeout};
            tpd_pkg::REG_COOLDOWN: prdata = {26'd0, cfg_reg.cooldown};
            tpd_pkg::REG_STARTUP:  prdata = {22'd0, cfg_reg.startup};
            default:               prdata = '0;
        endcase
    end

    tpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tpd_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .cfg      (cfg_reg),
        .in_data  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ sv/tpd_ctrl.sv @@
// Frame sequencer: steps the datapath through one frame per accepted beat.
`timescale 1ns / 1ps

module tpd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tpd_pkg::stat_t  stat,
    output tpd_pkg::cmd_t   cmd
);

    tpd_pkg::state_t state_reg;
    tpd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpd_pkg::ST_WAIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            tpd_pkg::ST_WAIT:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = stat.enable ? tpd_pkg::ST_SUM : tpd_pkg::ST_OUT;
                end
            end
            tpd_pkg::ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = tpd_pkg::ST_AMUL;
            end
            tpd_pkg::ST_AMUL:
            begin
                cmd.amul   = 1'b1;
                state_next = tpd_pkg::ST_AADD;
            end
            tpd_pkg::ST_AADD:
            begin
                cmd.aadd   = 1'b1;
                state_next = tpd_pkg::ST_TMUL;
            end
            tpd_pkg::ST_TMUL:
            begin
                cmd.tmul   = 1'b1;
                state_next = tpd_pkg::ST_DECIDE;
            end
            tpd_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = stat.reload ? tpd_pkg::ST_RMUL : tpd_pkg::ST_OUT;
            end
            tpd_pkg::ST_RMUL:
            begin
                cmd.tmul   = 1'b1;
                state_next = tpd_pkg::ST_RLOAD;
            end
            tpd_pkg::ST_RLOAD:
            begin
                cmd.rload  = 1'b1;
                state_next = tpd_pkg::ST_OUT;
            end
            tpd_pkg::ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = tpd_pkg::ST_WAIT;
                end
            end
            default:
            begin
                state_next = tpd_pkg::ST_WAIT;
            end
        endcase
    end

endmodule

@@ sv/tpd_datapath.sv @@
// Window ring, baseline filter, threshold, pulse tracker and output register.
`timescale 1ns / 1ps

module tpd_datapath #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tpd_pkg::cmd_t                cmd,
    output tpd_pkg::stat_t               stat,
    input  tpd_pkg::cfg_t                cfg,
    input  logic [tpd_pkg::IN_W-1:0]     in_data,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [tpd_pkg::TDATA_W-1:0]  m_tdata,
    output logic [tpd_pkg::TUSER_W-1:0]  m_tuser
);

    localparam int POS_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = tpd_pkg::IN_W + FILL_W;
    localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(WINDOW_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_DEPTH);

    // window ring
    logic [tpd_pkg::IN_W-1:0] ring_mem [WINDOW_DEPTH];
    logic [tpd_pkg::IN_W-1:0] rd_reg;
    logic [tpd_pkg::IN_W-1:0] e_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [FILL_W-1:0]        fill_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [SUM_W-1:0]         sum_next;

    // frame bookkeeping
    logic [31:0]              frame_reg;
    logic [31:0]              cur_frame_reg;
    logic                     warm_done_reg;
    tpd_pkg::phase_t          phase_reg;

    // baseline and threshold
    logic [27:0]              base_reg;
    logic [27:0]              base_next;
    logic [31:0]              thr_reg;
    logic [tpd_pkg::PROD_W-1:0] aprod_reg;
    logic [tpd_pkg::PROD_W-1:0] tprod_reg;
    logic                     down_reg;
    logic                     adapt_reg;

    // pulse tracker
    tpd_pkg::mode_t           mode_reg;
    tpd_pkg::mode_t           mode_next;
    logic [31:0]              start_reg;
    logic [31:0]              start_next;
    logic [27:0]              peak_reg;
    logic [27:0]              peak_next;
    logic [5:0]               len_reg;
    logic [5:0]               len_next;
    logic [1:0]               low_reg;
    logic [1:0]               low_next;
    logic [5:0]               cool_reg;
    logic [5:0]               cool_next;
    logic [15:0]              good_reg;
    logic [15:0]              good_next;
    logic [15:0]              bad_reg;
    logic [15:0]              bad_next;

    // event held for the result beat
    logic                     ev_started_reg;
    logic                     ev_started_next;
    tpd_pkg::kind_t           ev_kind_reg;
    tpd_pkg::kind_t           ev_kind_next;
    logic [31:0]              ev_start_reg;
    logic [31:0]              ev_start_next;
    logic [5:0]               ev_len_reg;
    logic [5:0]               ev_len_next;
    logic [27:0]              ev_peak_reg;
    logic [27:0]              ev_peak_next;
    logic                     reload_next;

    logic                     m_tvalid_reg;
    logic [tpd_pkg::TDATA_W-1:0] m_tdata_reg;
    logic [tpd_pkg::TUSER_W-1:0] m_tuser_reg;

    logic [31:0]              sum_ext;
    logic [27:0]              lv;
    logic [27:0]              diff;
    logic [15:0]              rate_sel;
    logic [44:0]              arnd;
    logic [28:0]              inc;
    logic [29:0]              up_sum;
    logic [44:0]              trnd;
    logic [36:0]              tsh;
    logic [31:0]              thr_new;
    logic [31:0]              thr_eff;
    logic                     expired;
    logic                     valid_len;

    assign sum_ext = 32'(sum_reg);
    assign lv      = (sum_ext > {4'd0, tpd_pkg::MAX28}) ? tpd_pkg::MAX28 : sum_ext[27:0];

    assign sum_next = sum_reg - ((fill_reg == FILL_FULL) ? SUM_W'(rd_reg) : '0)
                      + SUM_W'(e_reg);

    assign diff     = (lv >= base_reg) ? (lv - base_reg) : (base_reg - lv);
    assign rate_sel = (phase_reg == tpd_pkg::PH_WARM) ? tpd_pkg::WARM_RATE : cfg.rate;

    // base moves toward lv by round(rate * |lv - base| / 65536), half away from zero, clamped
    assign arnd   = {1'b0, aprod_reg} + 45'd32768;
    assign inc    = arnd[44:16];
    assign up_sum = {2'b00, base_reg} + {1'b0, inc};

    always_comb
    begin
        if (down_reg)
        begin
            base_next = (inc > {1'b0, base_reg}) ? '0 : (base_reg - inc[27:0]);
        end
        else
        begin
            base_next = (up_sum > {2'b00, tpd_pkg::MAX28}) ? tpd_pkg::MAX28 : up_sum[27:0];
        end
        if (phase_reg == tpd_pkg::PH_RUN && base_next < tpd_pkg::BASE_FLOOR)
        begin
            base_next = tpd_pkg::BASE_FLOOR;
        end
    end

    assign trnd    = {1'b0, tprod_reg} + 45'd128;
    assign tsh     = trnd[44:8];
    assign thr_new = (|tsh[36:32]) ? 32'hFFFF_FFFF : tsh[31:0];
    assign thr_eff = adapt_reg ? thr_new : thr_reg;

    assign len_next  = (phase_reg == tpd_pkg::PH_RUN && mode_reg == tpd_pkg::MODE_PULSE &&
                        len_reg < tpd_pkg::LEN_MAX) ? (len_reg + 6'd1) : len_reg;
    assign expired   = len_next >= cfg.timeout;
    assign valid_len = (len_next >= cfg.min_len) && (len_next <= cfg.max_len);

    always_comb
    begin
        mode_next       = mode_reg;
        start_next      = start_reg;
        peak_next       = peak_reg;
        low_next        = low_reg;
        cool_next       = cool_reg;
        good_next       = good_reg;
        bad_next        = bad_reg;
        ev_started_next = 1'b0;
        ev_kind_next    = tpd_pkg::KIND_NONE;
        ev_start_next   = '0;
        ev_len_next     = '0;
        ev_peak_next    = '0;
        reload_next     = 1'b0;
        if (phase_reg == tpd_pkg::PH_RUN)
        begin
            case (mode_reg)
                tpd_pkg::MODE_IDLE:
                begin
                    if ({4'd0, lv} > thr_eff)
                    begin
                        mode_next       = tpd_pkg::MODE_PULSE;
                        start_next      = cur_frame_reg;
                        peak_next       = lv;
                        low_next        = '0;
                        ev_started_next = 1'b1;
                    end
                end
                tpd_pkg::MODE_PULSE:
                begin
                    if (lv > peak_reg)
                    begin
                        peak_next = lv;
                    end
                    if ({4'd0, lv} < thr_eff)
                    begin
                        low_next = (low_reg < tpd_pkg::LOW_NEEDED) ? (low_reg + 2'd1) : low_reg;
                    end
                    else
                    begin
                        low_next = '0;
                    end
                    if (low_next >= tpd_pkg::LOW_NEEDED || expired)
                    begin
                        if (valid_len)
                        begin
                            ev_kind_next = tpd_pkg::KIND_VALID;
                            good_next    = (good_reg < tpd_pkg::CNT_MAX) ? (good_reg + 16'd1)
                                                                         : good_reg;
                        end
                        else
                        begin
                            ev_kind_next = expired ? tpd_pkg::KIND_TIMEOUT
                                                   : tpd_pkg::KIND_LENGTH;
                            reload_next  = expired;
                            bad_next     = (bad_reg < tpd_pkg::CNT_MAX) ? (bad_reg + 16'd1)
                                                                        : bad_reg;
                        end
                        ev_start_next = start_reg;
                        ev_len_next   = len_next;
                        ev_peak_next  = peak_next;
                        mode_next     = tpd_pkg::MODE_COOL;
                        cool_next     = cfg.cooldown;
                    end
                end
                default:
                begin
                    if (cool_reg <= 6'd1)
                    begin
                        cool_next = '0;
                        mode_next = tpd_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        cool_next = cool_reg - 6'd1;
                    end
                end
            endcase
        end
    end

    // ring storage, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_reg <= ring_mem[pos_reg];
            e_reg  <= in_data;
        end
        if (cmd.sum)
        begin
            ring_mem[pos_reg] <= e_reg;
        end
    end

    // products, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.amul)
        begin
            aprod_reg <= tpd_pkg::PROD_W'(diff * rate_sel);
            down_reg  <= lv < base_reg;
            adapt_reg <= (phase_reg != tpd_pkg::PH_RUN) || (mode_reg == tpd_pkg::MODE_IDLE);
        end
        if (cmd.tmul)
        begin
            tprod_reg <= tpd_pkg::PROD_W'(base_reg * cfg.gain);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            fill_reg       <= '0;
            sum_reg        <= '0;
            frame_reg      <= '0;
            cur_frame_reg  <= '0;
            warm_done_reg  <= 1'b0;
            phase_reg      <= tpd_pkg::PH_WARM;
            base_reg       <= tpd_pkg::BASE_FLOOR;
            thr_reg        <= tpd_pkg::THR_RESET;
            mode_reg       <= tpd_pkg::MODE_IDLE;
            start_reg      <= '0;
            peak_reg       <= '0;
            len_reg        <= '0;
            low_reg        <= '0;
            cool_reg       <= '0;
            good_reg       <= '0;
            bad_reg        <= '0;
            ev_started_reg <= 1'b0;
            ev_kind_reg    <= tpd_pkg::KIND_NONE;
            ev_start_reg   <= '0;
            ev_len_reg     <= '0;
            ev_peak_reg    <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                ev_started_reg <= 1'b0;
                ev_kind_reg    <= tpd_pkg::KIND_NONE;
                ev_start_reg   <= '0;
                ev_len_reg     <= '0;
                ev_peak_reg    <= '0;
                if (cfg.enable)
                begin
                    cur_frame_reg <= frame_reg;
                    frame_reg     <= frame_reg + 32'd1;
                    if (!warm_done_reg)
                    begin
                        phase_reg <= tpd_pkg::PH_WARM;
                        if (frame_reg >= tpd_pkg::WARM_LAST)
                        begin
                            warm_done_reg <= 1'b1;
                        end
                    end
                    else if (frame_reg < {22'd0, cfg.startup})
                    begin
                        phase_reg <= tpd_pkg::PH_HOLD;
                    end
                    else
                    begin
                        phase_reg <= tpd_pkg::PH_RUN;
                    end
                end
            end
            if (cmd.sum)
            begin
                sum_reg  <= sum_next;
                pos_reg  <= (pos_reg == POS_LAST) ? '0 : (pos_reg + POS_W'(1));
                fill_reg <= (fill_reg == FILL_FULL) ? fill_reg : (fill_reg + FILL_W'(1));
            end
            if (cmd.aadd && adapt_reg)
            begin
                base_reg <= base_next;
            end
            if (cmd.decide)
            begin
                if (adapt_reg)
                begin
                    thr_reg <= thr_new;
                end
                if (reload_next)
                begin
                    base_reg <= lv;
                end
                mode_reg       <= mode_next;
                start_reg      <= start_next;
                peak_reg       <= peak_next;
                len_reg        <= (phase_reg == tpd_pkg::PH_RUN &&
                                   mode_reg == tpd_pkg::MODE_IDLE && mode_next ==
                                   tpd_pkg::MODE_PULSE) ? 6'd1 : len_next;
                low_reg        <= low_next;
                cool_reg       <= cool_next;
                good_reg       <= good_next;
                bad_reg        <= bad_next;
                ev_started_reg <= ev_started_next;
                ev_kind_reg    <= ev_kind_next;
                ev_start_reg   <= ev_start_next;
                ev_len_reg     <= ev_len_next;
                ev_peak_reg    <= ev_peak_next;
            end
            if (cmd.rload)
            begin
                thr_reg <= thr_new;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            m_tdata_reg <= {6'd0, bad_reg, good_reg, thr_reg, base_reg, lv,
                            ev_peak_reg, ev_len_reg, ev_start_reg};
            m_tuser_reg <= {ev_kind_reg, ev_started_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign stat.enable   = cfg.enable;
    assign stat.reload   = reload_next;
    assign stat.out_free = !m_tvalid_reg || m_tready;

endmodule

@@ sv/tpd_checker.sv @@
// Port-level checks for the tone pulse detector, bound to the top level.
`timescale 1ns / 1ps

module tpd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tpd_pkg::TDATA_W-1:0]   m_tdata,
    input logic [tpd_pkg::TUSER_W-1:0]   m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat dropped or changed while stalled");

    a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second frame taken while one is in work");

    a_start_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[2:1] != tpd_pkg::KIND_NONE) |-> !m_tuser[0])
        else $error("pulse start and pulse end in the same beat");

    a_no_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[2:1] == tpd_pkg::KIND_NONE) |->
            (m_tdata[37:32] == 6'd0) && (m_tdata[65:38] == 28'd0))
        else $error("event fields set without an event");

    a_event_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[2:1] != tpd_pkg::KIND_NONE) |-> (m_tdata[37:32] != 6'd0))
        else $error("ended pulse with zero length");

endmodule

bind tone_pulse_detector_adaptive_baseline_unit tpd_checker u_tpd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
